>>> rtl/core/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// shared types, codes and constants of the sensor compensation block
// ----------------------------------------------------------------------------
package esc_pkg;

    typedef logic [1:0]         kind_t;
    typedef logic [19:0]        raw_t;
    typedef logic signed [31:0] value_t;
    typedef logic [63:0]        word_t;

    localparam kind_t KIND_TEMP = 2'd0;
    localparam kind_t KIND_PRES = 2'd1;
    localparam kind_t KIND_HUM  = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_TEMP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRES_A   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRES_B   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRES_HUM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_HUM      = 3'd4;

    // shared unit operations
    typedef logic [2:0] op_t;
    localparam op_t OP_ADD   = 3'd0;
    localparam op_t OP_SUB   = 3'd1;
    localparam op_t OP_ASR   = 3'd2;
    localparam op_t OP_LSR   = 3'd3;
    localparam op_t OP_SHL   = 3'd4;
    localparam op_t OP_MUL   = 3'd5;
    localparam op_t OP_DIV   = 3'd6;
    localparam op_t OP_CLAMP = 3'd7;

    localparam int NUM_TMP = 6;
    localparam int DIV_STEPS = 64;

    localparam word_t C_64000     = 64'd64000;
    localparam word_t C_0X100000  = 64'h100000;
    localparam word_t C_3125      = 64'd3125;
    localparam word_t C_0X80000000 = 64'h80000000;
    localparam word_t C_76800     = 64'd76800;
    localparam word_t C_HUM_MAX   = 64'd419430400;
    localparam word_t C_16384     = 64'd16384;
    localparam word_t C_2097152   = 64'd2097152;
    localparam word_t C_0X8000    = 64'h8000;
    localparam word_t C_32768     = 64'd32768;
    localparam word_t C_8192      = 64'd8192;
    localparam word_t C_128       = 64'd128;

endpackage

>>> rtl/core/esc_if.sv
// ----------------------------------------------------------------------------
// esc_if
// valid/ready channels for sample items and result items
// ----------------------------------------------------------------------------
interface esc_sample_if;
    import esc_pkg::*;
    logic  valid;
    logic  ready;
    kind_t req_type;
    raw_t  raw_sample;

    modport source (output valid, output req_type, output raw_sample, input ready);
    modport sink (input valid, input req_type, input raw_sample, output ready);
endinterface

interface esc_result_if;
    import esc_pkg::*;
    logic   valid;
    logic   ready;
    value_t comp_value;
    kind_t  value_kind;
    logic   divisor_zero;

    modport source (output valid, output comp_value, output value_kind,
                    output divisor_zero, input ready);
    modport sink (input valid, input comp_value, input value_kind,
                  input divisor_zero, output ready);
endinterface

>>> rtl/core/environmental_sensor_compensation.sv
// ----------------------------------------------------------------------------
// environmental_sensor_compensation
// integer compensation of temperature, pressure and humidity samples
// ----------------------------------------------------------------------------
// sample channel: one raw item with its kind; ready only while no item is
// being worked on. result channel: one item per sample, held in an output
// register, so the next sample may be taken while the result still waits.
// calibration words are written through cfg_we/cfg_index/cfg_data while idle.
// a small sequencer steps through each formula on one 64-bit add/shift unit,
// a 64x64 multiplier built on a 32x32 multiplier and a one-bit-a-cycle 64-bit
// divider. temperature takes 3 multiplies, humidity 8 and pressure 10 and the
// divide, or it ends early with a flagged zero when the divisor is zero;
// an unused kind gives a zero result.
// the block takes a new sample the cycle after the previous result is
// registered. if the receiver stalls with a result still held, the last step
// of the next item waits until that result is taken.
// reset clears calibration words, fine temperature and all handshake state.
// ----------------------------------------------------------------------------
module environmental_sensor_compensation (
    input  logic                           clk,
    input  logic                           rst_n,
    esc_sample_if.sink                     sample,
    esc_result_if.source                   result,
    input  logic                           cfg_we,
    input  logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [esc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import esc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [47:0] cal_temp_reg;
    logic [63:0] cal_pres_a_reg;
    logic [63:0] cal_pres_b_reg;
    logic [47:0] cal_pres_hum_reg;
    logic [31:0] cal_hum_reg;
    logic [31:0] fine_reg;

    logic [1:0]  state_reg;
    logic [5:0]  pc_reg;
    kind_t       kind_reg;
    raw_t        raw_reg;
    logic        big_reg;
    word_t       tmp_reg [NUM_TMP];

    logic        out_valid_reg;
    value_t      out_value_reg;
    kind_t       out_kind_reg;
    logic        out_dz_reg;

    // decoded step
    op_t         op;
    logic [2:0]  dst;
    word_t       opa;
    word_t       opb;
    logic [4:0]  sh;
    logic        fin;
    logic        wr_fine;
    logic        set_dz;
    logic        chk_big;

    word_t       alu_res;
    logic        mul_start;
    logic        mul_done;
    word_t       mul_prod;
    logic        div_start;
    logic        div_done;
    word_t       div_quo;
    logic        out_free;
    logic        num_small;

    // calibration fields, sign or zero extended to the datapath width
    word_t t1, t2, t3;
    word_t p1, p2, p3, p4, p5, p6, p7, p8, p9;
    word_t h1, h2, h3, h4, h5, h6;
    word_t ft, raw64;

    always_comb
    begin
        t1 = {48'd0, cal_temp_reg[15:0]};
        t2 = {{48{cal_temp_reg[31]}}, cal_temp_reg[31:16]};
        t3 = {{48{cal_temp_reg[47]}}, cal_temp_reg[47:32]};
        p1 = {48'd0, cal_pres_a_reg[15:0]};
        p2 = {{48{cal_pres_a_reg[31]}}, cal_pres_a_reg[31:16]};
        p3 = {{48{cal_pres_a_reg[47]}}, cal_pres_a_reg[47:32]};
        p4 = {{48{cal_pres_a_reg[63]}}, cal_pres_a_reg[63:48]};
        p5 = {{48{cal_pres_b_reg[15]}}, cal_pres_b_reg[15:0]};
        p6 = {{48{cal_pres_b_reg[31]}}, cal_pres_b_reg[31:16]};
        p7 = {{48{cal_pres_b_reg[47]}}, cal_pres_b_reg[47:32]};
        p8 = {{48{cal_pres_b_reg[63]}}, cal_pres_b_reg[63:48]};
        p9 = {{48{cal_pres_hum_reg[15]}}, cal_pres_hum_reg[15:0]};
        h1 = {56'd0, cal_pres_hum_reg[23:16]};
        h2 = {{48{cal_pres_hum_reg[39]}}, cal_pres_hum_reg[39:24]};
        h3 = {56'd0, cal_pres_hum_reg[47:40]};
        h4 = {{52{cal_hum_reg[11]}}, cal_hum_reg[11:0]};
        h5 = {{52{cal_hum_reg[23]}}, cal_hum_reg[23:12]};
        h6 = {{56{cal_hum_reg[31]}}, cal_hum_reg[31:24]};
        ft = {{32{fine_reg[31]}}, fine_reg};
        raw64 = {44'd0, raw_reg};
    end

    assign num_small = tmp_reg[4] < C_0X80000000;

    // step decode: one operation of the shared units per step
    always_comb
    begin
        op      = OP_ADD;
        dst     = 3'd0;
        opa     = '0;
        opb     = '0;
        sh      = 5'd0;
        fin     = 1'b0;
        wr_fine = 1'b0;
        set_dz  = 1'b0;
        chk_big = 1'b0;
        case (kind_reg)
            KIND_TEMP:
            begin
                case (pc_reg)
                    6'd0:  begin op = OP_SUB; dst = 3'd0;
                                 opa = {3'd0, raw64[63:3]}; opb = {t1[62:0], 1'b0}; end
                    6'd1:  begin op = OP_MUL; dst = 3'd0; opa = tmp_reg[0]; opb = t2; end
                    6'd2:  begin op = OP_ASR; dst = 3'd0; opa = tmp_reg[0]; sh = 5'd11; end
                    6'd3:  begin op = OP_SUB; dst = 3'd1;
                                 opa = {4'd0, raw64[63:4]}; opb = t1; end
                    6'd4:  begin op = OP_MUL; dst = 3'd1; opa = tmp_reg[1]; opb = tmp_reg[1]; end
                    6'd5:  begin op = OP_ASR; dst = 3'd1; opa = tmp_reg[1]; sh = 5'd12; end
                    6'd6:  begin op = OP_MUL; dst = 3'd1; opa = tmp_reg[1]; opb = t3; end
                    6'd7:  begin op = OP_ASR; dst = 3'd1; opa = tmp_reg[1]; sh = 5'd14; end
                    6'd8:  begin op = OP_ADD; dst = 3'd0; opa = tmp_reg[0]; opb = tmp_reg[1];
                                 wr_fine = 1'b1; end
                    // fine * 5 as fine * 4 + fine
                    6'd9:  begin op = OP_ADD; dst = 3'd0; opa = {ft[61:0], 2'd0}; opb = ft; end
                    6'd10: begin op = OP_ADD; dst = 3'd0; opa = tmp_reg[0]; opb = C_128; end
                    default:
                    begin
                        op = OP_ASR; dst = 3'd0; opa = tmp_reg[0]; sh = 5'd8; fin = 1'b1;
                    end
                endcase
            end
            KIND_PRES:
            begin
                case (pc_reg)
                    6'd0:  begin op = OP_SUB; dst = 3'd0;
                                 opa = {ft[63], ft[63:1]}; opb = C_64000; end
                    6'd1:  begin op = OP_ASR; dst = 3'd1; opa = tmp_reg[0]; sh = 5'd2; end
                    6'd2:  begin op = OP_MUL; dst = 3'd1; opa = tmp_reg[1]; opb = tmp_reg[1]; end
                    6'd3:  begin op = OP_ASR; dst = 3'd2; opa = tmp_reg[1]; sh = 5'd11; end
                    6'd4:  begin op = OP_MUL; dst = 3'd2; opa = tmp_reg[2]; opb = p6; end
                    6'd5:  begin op = OP_MUL; dst = 3'd3; opa = tmp_reg[0]; opb = p5; end
                    6'd6:  begin op = OP_ADD; dst = 3'd2; opa = tmp_reg[2];
                                 opb = {tmp_reg[3][62:0], 1'b0}; end
                    6'd7:  begin op = OP_ASR; dst = 3'd2; opa = tmp_reg[2]; sh = 5'd2; end
                    6'd8:  begin op = OP_ADD; dst = 3'd2; opa = tmp_reg[2];
                                 opb = {p4[47:0], 16'd0}; end
                    6'd9:  begin op = OP_ASR; dst = 3'd3; opa = tmp_reg[1]; sh = 5'd13; end
                    6'd10: begin op = OP_MUL; dst = 3'd3; opa = p3; opb = tmp_reg[3]; end
                    6'd11: begin op = OP_ASR; dst = 3'd3; opa = tmp_reg[3]; sh = 5'd3; end
                    6'd12: begin op = OP_MUL; dst = 3'd4; opa = p2; opb = tmp_reg[0]; end
                    6'd13: begin op = OP_ADD; dst = 3'd3; opa = tmp_reg[3];
                                 opb = {tmp_reg[4][63], tmp_reg[4][63:1]}; end
                    6'd14: begin op = OP_ASR; dst = 3'd3; opa = tmp_reg[3]; sh = 5'd18; end
                    6'd15: begin op = OP_ADD; dst = 3'd3; opa = C_0X8000; opb = tmp_reg[3]; end
                    6'd16: begin op = OP_MUL; dst = 3'd3; opa = tmp_reg[3]; opb = p1; end
                    6'd17: begin op = OP_ASR; dst = 3'd3; opa = tmp_reg[3]; sh = 5'd15; end
                    6'd18:
                    begin
                        if (tmp_reg[3] == '0)
                        begin
                            // zero divisor ends the item with a flagged zero
                            fin = 1'b1; set_dz = 1'b1;
                        end
                        else
                        begin
                            op = OP_SUB; dst = 3'd4; opa = C_0X100000; opb = raw64;
                        end
                    end
                    6'd19: begin op = OP_SUB; dst = 3'd4; opa = tmp_reg[4];
                                 opb = {{12{tmp_reg[2][63]}}, tmp_reg[2][63:12]}; end
                    6'd20: begin op = OP_MUL; dst = 3'd4; opa = tmp_reg[4]; opb = C_3125; end
                    // small numerator is doubled before the divide, large after it
                    6'd21: begin op = OP_SHL; dst = 3'd4; opa = tmp_reg[4];
                                 sh = {4'd0, num_small}; chk_big = 1'b1; end
                    6'd22: begin op = OP_DIV; dst = 3'd4; opa = tmp_reg[4]; opb = tmp_reg[3]; end
                    6'd23: begin op = OP_SHL; dst = 3'd4; opa = tmp_reg[4];
                                 sh = {4'd0, big_reg}; end
                    6'd24: begin op = OP_LSR; dst = 3'd5; opa = tmp_reg[4]; sh = 5'd3; end
                    6'd25: begin op = OP_MUL; dst = 3'd5; opa = tmp_reg[5]; opb = tmp_reg[5]; end
                    6'd26: begin op = OP_LSR; dst = 3'd5; opa = tmp_reg[5]; sh = 5'd13; end
                    6'd27: begin op = OP_MUL; dst = 3'd5; opa = p9; opb = tmp_reg[5]; end
                    6'd28: begin op = OP_ASR; dst = 3'd5; opa = tmp_reg[5]; sh = 5'd12; end
                    6'd29: begin op = OP_LSR; dst = 3'd0; opa = tmp_reg[4]; sh = 5'd2; end
                    6'd30: begin op = OP_MUL; dst = 3'd0; opa = tmp_reg[0]; opb = p8; end
                    6'd31: begin op = OP_ASR; dst = 3'd0; opa = tmp_reg[0]; sh = 5'd13; end
                    6'd32: begin op = OP_ADD; dst = 3'd0; opa = tmp_reg[5]; opb = tmp_reg[0]; end
                    6'd33: begin op = OP_ADD; dst = 3'd0; opa = tmp_reg[0]; opb = p7; end
                    6'd34: begin op = OP_ASR; dst = 3'd0; opa = tmp_reg[0]; sh = 5'd4; end
                    default:
                    begin
                        op = OP_ADD; dst = 3'd0; opa = tmp_reg[4]; opb = tmp_reg[0]; fin = 1'b1;
                    end
                endcase
            end
            KIND_HUM:
            begin
                case (pc_reg)
                    6'd0:  begin op = OP_SUB; dst = 3'd0; opa = ft; opb = C_76800; end
                    6'd1:  begin op = OP_SUB; dst = 3'd1;
                                 opa = {34'd0, raw_reg[15:0], 14'd0}; opb = {h4[43:0], 20'd0}; end
                    6'd2:  begin op = OP_MUL; dst = 3'd2; opa = h5; opb = tmp_reg[0]; end
                    6'd3:  begin op = OP_SUB; dst = 3'd1; opa = tmp_reg[1]; opb = tmp_reg[2]; end
                    6'd4:  begin op = OP_ADD; dst = 3'd1; opa = tmp_reg[1]; opb = C_16384; end
                    6'd5:  begin op = OP_ASR; dst = 3'd1; opa = tmp_reg[1]; sh = 5'd15; end
                    6'd6:  begin op = OP_MUL; dst = 3'd2; opa = tmp_reg[0]; opb = h6; end
                    6'd7:  begin op = OP_ASR; dst = 3'd2; opa = tmp_reg[2]; sh = 5'd10; end
                    6'd8:  begin op = OP_MUL; dst = 3'd3; opa = tmp_reg[0]; opb = h3; end
                    6'd9:  begin op = OP_ASR; dst = 3'd3; opa = tmp_reg[3]; sh = 5'd11; end
                    6'd10: begin op = OP_ADD; dst = 3'd3; opa = tmp_reg[3]; opb = C_32768; end
                    6'd11: begin op = OP_MUL; dst = 3'd2; opa = tmp_reg[2]; opb = tmp_reg[3]; end
                    6'd12: begin op = OP_ASR; dst = 3'd2; opa = tmp_reg[2]; sh = 5'd10; end
                    6'd13: begin op = OP_ADD; dst = 3'd2; opa = tmp_reg[2]; opb = C_2097152; end
                    6'd14: begin op = OP_MUL; dst = 3'd2; opa = tmp_reg[2]; opb = h2; end
                    6'd15: begin op = OP_ADD; dst = 3'd2; opa = tmp_reg[2]; opb = C_8192; end
                    6'd16: begin op = OP_ASR; dst = 3'd2; opa = tmp_reg[2]; sh = 5'd14; end
                    6'd17: begin op = OP_MUL; dst = 3'd1; opa = tmp_reg[1]; opb = tmp_reg[2]; end
                    6'd18: begin op = OP_ASR; dst = 3'd2; opa = tmp_reg[1]; sh = 5'd15; end
                    6'd19: begin op = OP_MUL; dst = 3'd2; opa = tmp_reg[2]; opb = tmp_reg[2]; end
                    6'd20: begin op = OP_ASR; dst = 3'd2; opa = tmp_reg[2]; sh = 5'd7; end
                    6'd21: begin op = OP_MUL; dst = 3'd2; opa = tmp_reg[2]; opb = h1; end
                    6'd22: begin op = OP_ASR; dst = 3'd2; opa = tmp_reg[2]; sh = 5'd4; end
                    6'd23: begin op = OP_SUB; dst = 3'd1; opa = tmp_reg[1]; opb = tmp_reg[2]; end
                    6'd24: begin op = OP_CLAMP; dst = 3'd1; opa = tmp_reg[1]; end
                    default:
                    begin
                        op = OP_LSR; dst = 3'd1; opa = tmp_reg[1]; sh = 5'd12; fin = 1'b1;
                    end
                endcase
            end
            default:
            begin
                // unused kind: zero result, fine temperature untouched
                fin = 1'b1;
            end
        endcase
    end

    // shared add/shift unit
    always_comb
    begin
        case (op)
            OP_ADD:   alu_res = opa + opb;
            OP_SUB:   alu_res = opa - opb;
            OP_ASR:   alu_res = word_t'($signed(opa) >>> sh);
            OP_LSR:   alu_res = opa >> sh;
            OP_SHL:   alu_res = opa << sh;
            OP_CLAMP:
            begin
                if (opa[63])
                    alu_res = '0;
                else if (opa > C_HUM_MAX)
                    alu_res = C_HUM_MAX;
                else
                    alu_res = opa;
            end
            default:  alu_res = opa;
        endcase
    end

    assign mul_start = (state_reg == ST_RUN) && (op == OP_MUL);
    assign div_start = (state_reg == ST_RUN) && (op == OP_DIV);
    assign out_free  = !out_valid_reg || result.ready;

    esc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (opa),
        .b     (opb),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    esc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (opa),
        .divisor  (opb),
        .done     (div_done),
        .quotient (div_quo)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg     <= '0;
            cal_pres_a_reg   <= '0;
            cal_pres_b_reg   <= '0;
            cal_pres_hum_reg <= '0;
            cal_hum_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAL_TEMP:     cal_temp_reg     <= cfg_data[47:0];
                CFG_CAL_PRES_A:   cal_pres_a_reg   <= cfg_data;
                CFG_CAL_PRES_B:   cal_pres_b_reg   <= cfg_data;
                CFG_CAL_PRES_HUM: cal_pres_hum_reg <= cfg_data[47:0];
                CFG_CAL_HUM:      cal_hum_reg      <= cfg_data[31:0];
                default:          ;
            endcase
        end
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            kind_reg      <= KIND_TEMP;
            fine_reg      <= '0;
            big_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (sample.valid)
                    begin
                        kind_reg  <= sample.req_type;
                        pc_reg    <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (fin)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                    end
                    else if (op == OP_MUL || op == OP_DIV)
                        state_reg <= ST_WAIT;
                    else
                    begin
                        pc_reg <= pc_reg + 6'd1;
                        if (wr_fine)
                            fine_reg <= alu_res[31:0];
                        if (chk_big)
                            big_reg <= !num_small;
                    end
                end
                ST_WAIT:
                begin
                    if ((op == OP_MUL && mul_done) || (op == OP_DIV && div_done))
                    begin
                        pc_reg    <= pc_reg + 6'd1;
                        state_reg <= ST_RUN;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && sample.valid)
            raw_reg <= sample.raw_sample;
        if (state_reg == ST_RUN && !fin && op != OP_MUL && op != OP_DIV)
            tmp_reg[dst] <= alu_res;
        if (state_reg == ST_WAIT && op == OP_MUL && mul_done)
            tmp_reg[dst] <= mul_prod;
        if (state_reg == ST_WAIT && op == OP_DIV && div_done)
            tmp_reg[dst] <= div_quo;
        if (state_reg == ST_RUN && fin && out_free)
        begin
            out_value_reg <= set_dz ? '0 : alu_res[31:0];
            out_kind_reg  <= kind_reg;
            out_dz_reg    <= set_dz;
        end
    end

    assign sample.ready        = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.comp_value   = out_value_reg;
    assign result.value_kind   = out_kind_reg;
    assign result.divisor_zero = out_dz_reg;

`ifndef SYNTHESIS
    a_dz_only_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_dz_reg) |-> (out_kind_reg == KIND_PRES))
        else $error("divisor flag on a non-pressure result");

    a_fine_only_temp: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(fine_reg) |-> ($past(kind_reg) == KIND_TEMP))
        else $error("fine temperature changed outside a temperature item");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> (state_reg == ST_RUN))
        else $error("accepted item did not start");

    a_unit_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_done || div_done) |-> (state_reg == ST_WAIT))
        else $error("arithmetic unit finished outside a wait step");
`endif

endmodule

>>> rtl/core/esc_mul.sv
// ----------------------------------------------------------------------------
// esc_mul
// 64 x 64 multiply modulo 2^64 over one 32 x 32 multiplier
// ----------------------------------------------------------------------------
module esc_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  esc_pkg::word_t a,
    input  esc_pkg::word_t b,
    output logic           done,
    output esc_pkg::word_t prod
);
    import esc_pkg::*;

    word_t       a_reg;
    word_t       b_reg;
    word_t       part_reg;
    word_t       acc_reg;
    logic [1:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    word_t       mul_p;

    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                mul_a = a_reg[31:0];
                mul_b = b_reg[31:0];
            end
            2'd1:
            begin
                mul_a = a_reg[31:0];
                mul_b = b_reg[63:32];
            end
            default:
            begin
                mul_a = a_reg[63:32];
                mul_b = b_reg[31:0];
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // cross products only reach the upper half
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            part_reg <= mul_p;
            if (cnt_reg == 2'd1)
                acc_reg <= part_reg;
            else if (cnt_reg != 2'd0)
                acc_reg[63:32] <= acc_reg[63:32] + part_reg[31:0];
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> rtl/core/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// 64-bit unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module esc_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  esc_pkg::word_t dividend,
    input  esc_pkg::word_t divisor,
    output logic           done,
    output esc_pkg::word_t quotient
);
    import esc_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    word_t            rem_reg;
    word_t            quo_reg;
    word_t            dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [64:0]      rem_sh;
    logic [64:0]      trial;

    assign rem_sh = {rem_reg, quo_reg[63]};
    assign trial  = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                cnt_reg <= CNT_W'(DIV_STEPS);
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[64])
            begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
